// File: hdl/foc_position_pid_voltage_modulator_core_macros.svh
// assertion helpers for the position pid voltage modulator
`ifndef FOC_POSITION_PID_VOLTAGE_MODULATOR_CORE_MACROS_SVH
`define FOC_POSITION_PID_VOLTAGE_MODULATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FPM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FPM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FPM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/fpm_pkg.sv
`timescale 1ns / 1ps
package fpm_pkg;
  localparam int DIRECTION_DEF  = 1;
  localparam int ANGLE_BITS_DEF = 12;

  localparam logic signed [47:0] ERR_SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ERR_SUM_MIN = 48'sh8000_0000_0000;
  localparam logic [63:0] I_BOUND = 64'h1000_0000_0000_0000;
  localparam logic signed [21:0] TARGET_MAX = 22'sd1310720;
  localparam logic signed [21:0] TARGET_MIN = -22'sd1310720;
  localparam logic [16:0] SQRT3_Q16 = 17'd113512;

  // register indexes
  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_GAIN_P = 3'd1;
  localparam logic [2:0] REG_GAIN_I = 3'd2;
  localparam logic [2:0] REG_GAIN_D = 3'd3;
  localparam logic [2:0] REG_SUPPLY = 3'd4;
  localparam logic [2:0] REG_VLIMIT = 3'd5;
  localparam logic [2:0] REG_OFFSET = 3'd6;
  localparam logic [2:0] REG_POLES  = 3'd7;

  typedef struct packed {
    logic signed [21:0] setpoint;
    logic signed [23:0] gain_p;
    logic signed [23:0] gain_i;
    logic signed [23:0] gain_d;
    logic [13:0] supply_voltage;
    logic [13:0] voltage_limit;
    logic [11:0] zero_offset;
    logic [5:0]  pole_pairs;
  } cfg_t;

  // quarter sine, 0..16384 in, Q16 out
  function automatic logic [16:0] qsine(input logic [14:0] u);
    logic [63:0] z, z2, t, s;
    begin
      z  = {33'd0, u, 16'd0};
      z2 = (z * z) >> 30;
      t  = 64'd5026991 - ((z2 * 64'd172272) >> 30);
      t  = 64'd85569306 - ((z2 * t) >> 30);
      t  = 64'd693598668 - ((z2 * t) >> 30);
      t  = 64'd1686629713 - ((z2 * t) >> 30);
      s  = ((z * t) >> 30) >> 14;
      if (s > 64'd65536) s = 64'd65536;
      qsine = s[16:0];
    end
  endfunction
endpackage

// File: hdl/fpm_sine_rom.sv
`timescale 1ns / 1ps
module fpm_sine_rom #(
  parameter int ANGLE_BITS = fpm_pkg::ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic [15:0] turn,
  output logic signed [17:0] value
);
  import fpm_pkg::*;
  localparam int QB = ANGLE_BITS - 2;
  localparam int QN = 1 << QB;

  logic [16:0] rom [QN + 1];
  logic [QB:0] idx;
  logic [QB-1:0] r;
  logic [1:0] q;
  logic neg;

  // constant quarter-wave table, one extra entry for the peak
  always_comb begin
    for (int i = 0; i <= QN; i++) rom[i] = qsine(15'((i << (14 - QB))));
  end

  assign q = turn[15:14];
  assign r = turn[13 -: QB];
  assign idx = q[0] ? (QB+1)'(QN - int'(r)) : {1'b0, r};

  // registered lookup with quadrant sign
  always_ff @(posedge clk) begin
    neg   <= q[1];
    value <= q[1] ? -$signed({1'b0, rom[idx]}) : $signed({1'b0, rom[idx]});
  end
  logic unused;
  assign unused = neg;
endmodule

// File: hdl/fpm_regs.sv
`timescale 1ns / 1ps
module fpm_regs (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output fpm_pkg::cfg_t cfg
);
  import fpm_pkg::*;
  logic [2:0] idx;
  logic signed [21:0] tw;
  assign idx = paddr[4:2];
  assign pready = 1'b1;
  assign tw = $signed(pwdata[21:0]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint <= '0;
      cfg.gain_p <= 24'sd375491;
      cfg.gain_i <= '0;
      cfg.gain_d <= '0;
      cfg.supply_voltage <= 14'd3072;
      cfg.voltage_limit <= 14'd1536;
      cfg.zero_offset <= '0;
      cfg.pole_pairs <= 6'd7;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_TARGET: cfg.setpoint <= (tw > TARGET_MAX) ? TARGET_MAX :
                                    (tw < TARGET_MIN) ? TARGET_MIN : tw;
        REG_GAIN_P: cfg.gain_p <= $signed(pwdata[23:0]);
        REG_GAIN_I: cfg.gain_i <= $signed(pwdata[23:0]);
        REG_GAIN_D: cfg.gain_d <= $signed(pwdata[23:0]);
        REG_SUPPLY: cfg.supply_voltage <= pwdata[13:0];
        REG_VLIMIT: cfg.voltage_limit <= pwdata[13:0];
        REG_OFFSET: cfg.zero_offset <= pwdata[11:0];
        REG_POLES:  cfg.pole_pairs <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_TARGET: prdata = 32'($signed(cfg.setpoint));
      REG_GAIN_P: prdata = 32'($signed(cfg.gain_p));
      REG_GAIN_I: prdata = 32'($signed(cfg.gain_i));
      REG_GAIN_D: prdata = 32'($signed(cfg.gain_d));
      REG_SUPPLY: prdata = {18'd0, cfg.supply_voltage};
      REG_VLIMIT: prdata = {18'd0, cfg.voltage_limit};
      REG_OFFSET: prdata = {20'd0, cfg.zero_offset};
      REG_POLES:  prdata = {26'd0, cfg.pole_pairs};
      default:    prdata = '0;
    endcase
  end
endmodule

// File: hdl/foc_position_pid_voltage_modulator_core.sv
`timescale 1ns / 1ps
// the pid and park steps run first; each phase duty is then set directly when
// clipped, else by a restoring division
// input not ready while busy, taken again once the result is loaded for output;
// one shared 33x33 multiplier and one restoring divider (38 quotient bits)
// a result not taken holds the sequencer in its output state
// reset: synchronous, active high; registers to defaults, error sum cleared
module foc_position_pid_voltage_modulator_core #(
  parameter int DIRECTION  = fpm_pkg::DIRECTION_DEF,
  parameter int ANGLE_BITS = fpm_pkg::ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [47:0] s_tdata,   // position_angle[31:0], shaft_count[43:32]
  output logic m_tvalid,
  input  logic m_tready,
  output logic [39:0] m_tdata    // duty_a, duty_b, duty_c, drive_voltage[38:24]
);
  import fpm_pkg::*;
  `include "foc_position_pid_voltage_modulator_core_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_I, S_IL, S_IH, S_P, S_D, S_V, S_ANG, S_SIN, S_COS,
    S_AB, S_S3, S_PH, S_DIV, S_OUT
  } state_t;

  cfg_t cfg;
  state_t state;
  logic signed [47:0] error_sum;
  logic signed [31:0] last_error, err;
  logic signed [32:0] der;
  logic signed [65:0] acc;
  logic signed [14:0] v;
  logic [15:0] t16;
  logic signed [17:0] sn, cs, rom_val;
  logic signed [47:0] alpha, beta;
  logic signed [47:0] ph [3];
  logic [1:0] ph_i;
  logic [5:0] bit_i;
  logic [31:0] rem;
  logic [7:0] q;
  logic [7:0] duty [3];
  logic [31:0] pos_in;
  logic [11:0] cnt;
  logic [1:0] mstep;

  // shared signed multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  fpm_regs u_regs (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata,
                   .prdata, .pready, .cfg);
  fpm_sine_rom #(.ANGLE_BITS(ANGLE_BITS)) u_rom (.clk, .turn(t16), .value(rom_val));

  logic [23:0] vs;
  assign vs = {10'd0, (cfg.supply_voltage == 0) ? 14'd1 : cfg.supply_voltage};
  logic signed [48:0] errw;
  logic signed [48:0] sumw;
  logic signed [65:0] isat;
  logic signed [65:0] accf;
  logic [31:0] rem2;
  logic signed [47:0] u_now;
  logic [40:0] full, num;

  assign errw = 49'($signed(cfg.setpoint)) - 49'($signed(pos_in));
  assign sumw = 49'(error_sum) + 49'(err);
  assign accf = acc >>> 24;
  assign u_now = ph[ph_i] + 48'($signed({1'b0, vs, 15'd0}));
  assign full = {1'b0, vs, 16'd0};
  assign num = 41'(u_now) * 41'd255;

  // integral product from two halves of the error sum, clipped to +-2^60
  logic signed [71:0] iprod;
  logic [71:0] imag;
  assign iprod = (72'(mp) <<< 24) + 72'(acc);
  assign imag = iprod[71] ? 72'(-iprod) : 72'(iprod);
  assign isat = (imag > 72'(I_BOUND)) ? (iprod[71] ? -66'(I_BOUND) : 66'(I_BOUND))
                                      : 66'(iprod);

  always_comb begin
    ma = '0; mb = '0;
    unique case (state)
      S_IL: begin ma = 33'(cfg.gain_i); mb = $signed({9'd0, error_sum[23:0]}); end
      S_IH: begin ma = 33'(cfg.gain_i); mb = 33'($signed(error_sum[47:24])); end
      S_P:  begin ma = 33'(cfg.gain_p); mb = 33'(err); end
      S_D:  begin ma = 33'(cfg.gain_d); mb = der; end
      S_AB: begin ma = 33'(v); mb = mstep[0] ? 33'(cs) : 33'(sn); end
      S_S3: begin ma = $signed({16'd0, SQRT3_Q16}); mb = 33'(beta[32:0]); end
      default: ;
    endcase
  end

  logic [17:0] pc;
  assign pc = 18'(cfg.pole_pairs * cnt);
  assign rem2 = {rem[30:0], num[bit_i]};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      error_sum <= '0;
      last_error <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          pos_in <= s_tdata[31:0];
          cnt <= s_tdata[43:32];
          state <= S_ERR;
        end
        S_ERR: begin
          err <= (errw > 49'sd2147483647) ? 32'sh7FFFFFFF :
                 (errw < -49'sd2147483648) ? 32'sh80000000 : errw[31:0];
          state <= S_I;
        end
        S_I: begin
          error_sum <= (sumw > 49'(ERR_SUM_MAX)) ? ERR_SUM_MAX :
                       (sumw < 49'(ERR_SUM_MIN)) ? ERR_SUM_MIN : sumw[47:0];
          der <= 33'(err) - 33'(last_error);
          last_error <= err;
          state <= S_IL;
        end
        S_IL: begin
          acc <= mp;
          state <= S_IH;
        end
        S_IH: begin
          acc <= isat;
          state <= S_P;
        end
        S_P: begin
          acc <= acc + mp;
          state <= S_D;
        end
        S_D: begin
          acc <= acc + mp;
          state <= S_V;
        end
        S_V: begin
          if (accf > 66'($signed({1'b0, cfg.voltage_limit})))
            v <= $signed({1'b0, cfg.voltage_limit});
          else if (accf < -66'($signed({1'b0, cfg.voltage_limit})))
            v <= -$signed({1'b0, cfg.voltage_limit});
          else v <= accf[14:0];
          state <= S_ANG;
        end
        S_ANG: begin
          t16 <= ({12'((DIRECTION > 0) ? pc[11:0] : (DIRECTION < 0) ? -pc[11:0] : 12'd0)
                   - cfg.zero_offset, 4'd0} >> (16 - ANGLE_BITS)) << (16 - ANGLE_BITS);
          state <= S_SIN;
        end
        S_SIN: begin
          t16 <= t16 + 16'd16384;
          state <= S_COS;
        end
        S_COS: begin
          sn <= rom_val;
          mstep <= 2'd0;
          state <= S_AB;
        end
        S_AB: begin
          if (mstep == 2'd0) begin
            cs <= rom_val;
            alpha <= -48'(mp);
            mstep <= 2'd1;
          end else begin
            beta <= 48'(mp);
            state <= S_S3;
          end
        end
        S_S3: begin
          ph[0] <= alpha;
          ph[1] <= 48'((48'(mp >>> 16) - alpha) >>> 1);
          ph[2] <= 48'((alpha - 48'(mp >>> 16)) >>> 1);
          ph_i <= 2'd0;
          state <= S_PH;
        end
        S_PH: begin
          rem <= '0;
          q <= '0;
          bit_i <= 6'd37;
          if (u_now <= 0) begin
            duty[ph_i] <= 8'd0;
            state <= (ph_i == 2'd2) ? S_OUT : S_PH;
            ph_i <= ph_i + 2'd1;
          end else if (41'(u_now) >= full) begin
            duty[ph_i] <= 8'd255;
            state <= (ph_i == 2'd2) ? S_OUT : S_PH;
            ph_i <= ph_i + 2'd1;
          end else state <= S_DIV;
        end
        S_DIV: begin
          // one quotient bit a cycle, quotient below 255
          if (rem2 >= full[31:0]) begin
            rem <= rem2 - full[31:0];
            q <= {q[6:0], 1'b1};
          end else begin
            rem <= rem2;
            q <= {q[6:0], 1'b0};
          end
          bit_i <= bit_i - 6'd1;
          if (bit_i == 6'd0) begin
            duty[ph_i] <= {q[6:0], rem2 >= full[31:0]};
            ph_i <= ph_i + 2'd1;
            state <= (ph_i == 2'd2) ? S_OUT : S_PH;
          end
        end
        S_OUT: if (!m_tvalid) begin
          m_tdata <= {1'b0, v, duty[2], duty[1], duty[0]};
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  logic unused;
  assign unused = ^{accf[65:15], num[40:38], full[40:32]};

  `FPM_ASSERT_IMPL(a_busy_not_ready, clk, rst, state != S_IDLE, !s_tready)
  `FPM_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `FPM_ASSERT_IMPL(a_v_limit, clk, rst, m_tvalid,
                   $signed(m_tdata[38:24]) <= $signed({1'b0, cfg.voltage_limit}))
endmodule
